// File: rtl/core/dam_pkg.sv
// Shared types, codes and helpers of the decimal accumulator machine.
package dam_pkg;

  localparam int MEM_WORDS_DEF = 100;
  localparam int WORD_W = 15;
  localparam int PC_W = 7;
  localparam int OP_W = 7;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 15'sd9999;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_HALT      = 3'd1,
    ST_BAD_OP    = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_DIV_ZERO  = 3'd4,
    ST_PC_RANGE  = 3'd5,
    ST_STOPPED   = 3'd6
  } status_t;

  localparam logic [OP_W-1:0] OP_READ   = 7'd10;
  localparam logic [OP_W-1:0] OP_WRITE  = 7'd11;
  localparam logic [OP_W-1:0] OP_LOAD   = 7'd20;
  localparam logic [OP_W-1:0] OP_STORE  = 7'd21;
  localparam logic [OP_W-1:0] OP_ADD    = 7'd30;
  localparam logic [OP_W-1:0] OP_SUB    = 7'd31;
  localparam logic [OP_W-1:0] OP_DIV    = 7'd32;
  localparam logic [OP_W-1:0] OP_MUL    = 7'd33;
  localparam logic [OP_W-1:0] OP_BRANCH = 7'd40;
  localparam logic [OP_W-1:0] OP_BRNEG  = 7'd41;
  localparam logic [OP_W-1:0] OP_BRZERO = 7'd42;
  localparam logic [OP_W-1:0] OP_HALT   = 7'd43;

  // Clamp a word to the decimal range of the machine.
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WORD_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    r = v;
    if (v > WORD_MAX) begin
      r = WORD_MAX;
    end else if (v < -WORD_MAX) begin
      r = -WORD_MAX;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/decimal_accumulator_machine_top.sv
// Top level of the decimal accumulator machine: word store, sequencer and arithmetic.
//
// A word is taken when start is high and busy is low. A func=0 word writes one
// memory word and its result strobe, done, comes in the next cycle. An execute
// word for a machine that has stopped, or whose program counter lies past the
// store, also answers in the next cycle. Any other instruction fetches from the
// word store, splits the word into opcode and operand address, reads the
// operand and executes, passing through the S_FETCH, S_DECODE and S_OPER states
// before done; a negative instruction word is refused in S_FETCH, multiply
// goes on to S_MUL, and a divide by a non-zero word goes on to S_DIV, which
// runs a restoring divider one quotient bit a cycle. The store is a single
// memory with a registered read port. Results are shown for exactly one cycle
// and cannot be held off, and busy drops during the done cycle so the next
// word may be taken then. At reset the store reads as all zeros at once
// through a valid bit per entry; no clearing pass is needed.
module decimal_accumulator_machine_top #(
  parameter int MEM_WORDS = dam_pkg::MEM_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              func,
  input  logic [dam_pkg::PC_W-1:0]          load_addr,
  input  logic signed [dam_pkg::WORD_W-1:0] load_word,
  input  logic signed [dam_pkg::WORD_W-1:0] read_value,
  output logic                              done,
  output logic [2:0]                        status,
  output logic                              write_valid,
  output logic signed [dam_pkg::WORD_W-1:0] write_value,
  output logic                              read_taken,
  output logic [dam_pkg::PC_W-1:0]          next_pc,
  output logic signed [dam_pkg::WORD_W-1:0] acc_value,
  output logic                              halted
);
  import dam_pkg::*;

  // Address width of the store; a single-word store still needs one bit.
  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [PC_W-1:0] MemTop = PC_W'(MEM_WORDS);
  // Magnitudes of in-range words fit in fourteen bits.
  localparam int MAG_W = WORD_W - 1;
  localparam int CNT_W = $clog2(MAG_W + 1);
  localparam logic [CNT_W-1:0] DivSteps = CNT_W'(MAG_W);
  // Reciprocal of 100 scaled by 2^19; exact for every word up to 9999.
  localparam int RecipShift = 19;
  localparam logic [12:0] Recip100 = 13'd5243;
  localparam logic [OP_W-1:0] Hundred = 7'd100;
  localparam logic signed [WORD_W:0] SumMax = 16'sd9999;
  localparam logic signed [2*WORD_W-1:0] ProdMax = 30'sd9999;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FETCH  = 6'b000010,
    S_DECODE = 6'b000100,
    S_OPER   = 6'b001000,
    S_MUL    = 6'b010000,
    S_DIV    = 6'b100000
  } state_t;

  state_t state;

  // Architectural state beside the store.
  logic signed [WORD_W-1:0] acc;
  logic [PC_W-1:0]          pc;
  logic                     stopped;

  // Word store, its valid bits and its registered read port.
  logic signed [WORD_W-1:0] mem [MEM_WORDS];
  logic [MEM_WORDS-1:0]     vld;
  logic signed [WORD_W-1:0] rd_data;
  logic                     rd_vld;
  logic                     rd_en;
  logic [AW-1:0]            rd_idx;
  logic                     wr_en;
  logic [AW-1:0]            wr_idx;
  logic signed [WORD_W-1:0] wr_data;

  // Per-instruction working registers.
  logic signed [WORD_W-1:0] rv;
  logic [OP_W-1:0]          op;
  logic [PC_W-1:0]          ad;
  logic                     ad_ok;
  logic signed [2*WORD_W-1:0] prod;
  logic [MAG_W-1:0]         dvs;
  logic [MAG_W-1:0]         quo;
  logic [MAG_W:0]           rem;
  logic                     neg;
  logic [CNT_W-1:0]         cnt;

  // Result registers.
  logic                     done_q;
  status_t                  status_q;
  logic                     wvalid_q;
  logic signed [WORD_W-1:0] wvalue_q;
  logic                     rtaken_q;

  // Combinational helpers.
  logic                     accept;
  logic signed [WORD_W-1:0] fetched;
  logic signed [WORD_W-1:0] operand;
  logic [26:0]              op_prod;
  logic [MAG_W-1:0]         op_hund;
  logic [MAG_W-1:0]         ad_full;
  logic [PC_W-1:0]          ad_calc;
  logic                     ad_calc_ok;
  logic [PC_W-1:0]          pc_inc;
  logic signed [WORD_W:0]   sum;
  logic [MAG_W:0]           trial;
  logic [MAG_W-1:0]         acc_mag;
  logic [MAG_W-1:0]         opd_mag;
  logic signed [WORD_W-1:0] quo_s;

  assign accept  = start && !busy;
  assign busy    = rst || (state != S_IDLE);
  assign fetched = rd_vld ? rd_data : '0;
  assign operand = (rd_vld && ad_ok) ? rd_data : '0;
  assign pc_inc  = pc + PC_W'(1);

  // Opcode by multiplication with the reciprocal; address by one subtraction.
  assign op_prod    = fetched[MAG_W-1:0] * Recip100;
  assign op_hund    = MAG_W'(op) * MAG_W'(Hundred);
  assign ad_full    = fetched[MAG_W-1:0] - op_hund;
  assign ad_calc    = ad_full[PC_W-1:0];
  assign ad_calc_ok = ad_calc < MemTop;

  assign sum = (op == OP_SUB) ? ({acc[WORD_W-1], acc} - {operand[WORD_W-1], operand})
                              : ({acc[WORD_W-1], acc} + {operand[WORD_W-1], operand});

  assign acc_mag = acc[WORD_W-1]     ? MAG_W'(-acc)     : acc[MAG_W-1:0];
  assign opd_mag = operand[WORD_W-1] ? MAG_W'(-operand) : operand[MAG_W-1:0];
  assign trial   = {rem[MAG_W-1:0], quo[MAG_W-1]};
  assign quo_s   = $signed({1'b0, quo});

  // Store port selection: one read and one write a cycle at most.
  always_comb begin
    rd_en   = 1'b0;
    rd_idx  = pc[AW-1:0];
    wr_en   = 1'b0;
    wr_idx  = ad[AW-1:0];
    wr_data = acc;
    case (state)
      S_IDLE: begin
        if (accept && !func && (load_addr < MemTop)) begin
          wr_en   = 1'b1;
          wr_idx  = load_addr[AW-1:0];
          wr_data = sat_word(load_word);
        end
        if (accept && func && !stopped && (pc < MemTop)) begin
          rd_en = 1'b1;
        end
      end
      S_DECODE: begin
        rd_en  = ad_calc_ok;
        rd_idx = ad_calc[AW-1:0];
      end
      S_OPER: begin
        if (ad_ok && (op == OP_READ)) begin
          wr_en   = 1'b1;
          wr_data = rv;
        end else if (ad_ok && (op == OP_STORE)) begin
          wr_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_idx];
      end
    end
  end

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      acc     <= '0;
      pc      <= '0;
      stopped <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            rv       <= sat_word(read_value);
            status_q <= ST_OK;
            wvalid_q <= 1'b0;
            wvalue_q <= '0;
            rtaken_q <= 1'b0;
            if (!func) begin
              done_q <= 1'b1;
            end else if (stopped) begin
              status_q <= ST_STOPPED;
              done_q   <= 1'b1;
            end else if (pc >= MemTop) begin
              status_q <= ST_PC_RANGE;
              stopped  <= 1'b1;
              done_q   <= 1'b1;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          if (fetched[WORD_W-1]) begin
            status_q <= ST_BAD_OP;
            stopped  <= 1'b1;
            done_q   <= 1'b1;
            state    <= S_IDLE;
          end else begin
            op    <= op_prod[RecipShift +: OP_W];
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          ad    <= ad_calc;
          ad_ok <= ad_calc_ok;
          state <= S_OPER;
        end
        S_OPER: begin
          pc     <= pc_inc;
          done_q <= 1'b1;
          state  <= S_IDLE;
          case (op)
            OP_READ: begin
              rtaken_q <= 1'b1;
            end
            OP_WRITE: begin
              wvalid_q <= 1'b1;
              wvalue_q <= operand;
            end
            OP_LOAD: begin
              acc <= operand;
            end
            OP_STORE: begin
            end
            OP_ADD, OP_SUB: begin
              if ((sum > SumMax) || (sum < -SumMax)) begin
                status_q <= ST_OVERFLOW;
              end else begin
                acc <= sum[WORD_W-1:0];
              end
            end
            OP_MUL: begin
              prod   <= acc * operand;
              pc     <= pc;
              done_q <= 1'b0;
              state  <= S_MUL;
            end
            OP_DIV: begin
              if (operand == '0) begin
                status_q <= ST_DIV_ZERO;
              end else begin
                quo    <= acc_mag;
                dvs    <= opd_mag;
                rem    <= '0;
                neg    <= acc[WORD_W-1] ^ operand[WORD_W-1];
                cnt    <= DivSteps;
                pc     <= pc;
                done_q <= 1'b0;
                state  <= S_DIV;
              end
            end
            OP_BRANCH: begin
              pc <= ad;
            end
            OP_BRNEG: begin
              if (acc[WORD_W-1]) begin
                pc <= ad;
              end
            end
            OP_BRZERO: begin
              if (acc == '0) begin
                pc <= ad;
              end
            end
            OP_HALT: begin
              status_q <= ST_HALT;
              stopped  <= 1'b1;
              pc       <= pc;
            end
            default: begin
              status_q <= ST_BAD_OP;
              stopped  <= 1'b1;
              pc       <= pc;
            end
          endcase
        end
        S_MUL: begin
          if ((prod > ProdMax) || (prod < -ProdMax)) begin
            status_q <= ST_OVERFLOW;
          end else begin
            acc <= prod[WORD_W-1:0];
          end
          pc     <= pc_inc;
          done_q <= 1'b1;
          state  <= S_IDLE;
        end
        S_DIV: begin
          if (cnt != '0) begin
            // One restoring step: a quotient bit shifts in as a dividend bit leaves.
            if (trial >= {1'b0, dvs}) begin
              rem <= trial - {1'b0, dvs};
              quo <= {quo[MAG_W-2:0], 1'b1};
            end else begin
              rem <= trial;
              quo <= {quo[MAG_W-2:0], 1'b0};
            end
            cnt <= cnt - CNT_W'(1);
          end else begin
            acc    <= neg ? -quo_s : quo_s;
            pc     <= pc_inc;
            done_q <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign done        = done_q;
  assign status      = status_q;
  assign write_valid = wvalid_q;
  assign write_value = wvalue_q;
  assign read_taken  = rtaken_q;
  // State registers change no earlier than the edge that ends the done cycle.
  assign next_pc     = pc;
  assign acc_value   = acc;
  assign halted      = stopped;

endmodule

// File: rtl/core/dam_checker.sv
// Port-level checker of the decimal accumulator machine and its bind.
module dam_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              func,
  input logic [dam_pkg::PC_W-1:0]          load_addr,
  input logic signed [dam_pkg::WORD_W-1:0] load_word,
  input logic signed [dam_pkg::WORD_W-1:0] read_value,
  input logic                              done,
  input logic [2:0]                        status,
  input logic                              write_valid,
  input logic signed [dam_pkg::WORD_W-1:0] write_value,
  input logic                              read_taken,
  input logic [dam_pkg::PC_W-1:0]          next_pc,
  input logic signed [dam_pkg::WORD_W-1:0] acc_value,
  input logic                              halted
);
  import dam_pkg::*;

  // An accepted word is either still in work or answered in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word neither in work nor answered");

  // Every stopping outcome leaves the machine halted.
  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_HALT || status == ST_BAD_OP || status == ST_PC_RANGE ||
              status == ST_STOPPED)) |-> halted)
    else $error("stopping status without halted");

  // A memory write answers with status ok and no side outputs.
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !func) |=> (done && status == ST_OK && !write_valid && !read_taken))
    else $error("memory write gave a wrong result");

  // A stopped machine stays stopped.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted cleared without reset");

  // Output value is zero unless a write instruction produced it.
  a_wvalue_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !write_valid) |-> (write_value == '0))
    else $error("write_value set without write_valid");

endmodule

bind decimal_accumulator_machine_top dam_checker u_dam_checker (.*);

// File: dv/decimal_accumulator_machine_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the decimal accumulator machine: directed programs, random programs, stop causes.
module decimal_accumulator_machine_top_tb;
  import dam_pkg::*;

  localparam int NWORDS = MEM_WORDS_DEF;
  localparam int WORD_LIMIT = 9999;
  // Passes of the random program loop; with the patching writes this comes to
  // roughly seven hundred words in all.
  localparam int RANDOM_PASSES = 500;
  // The slowest correct run ends well within this limit.
  localparam int CYCLE_LIMIT = 200000;

  // What the machine reports for one word.
  typedef struct {
    status_t                  status;
    logic                     write_valid;
    logic signed [WORD_W-1:0] write_value;
    logic                     read_taken;
    logic [PC_W-1:0]          next_pc;
    logic signed [WORD_W-1:0] acc_value;
    logic                     halted;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic func = 1'b0;
  logic [PC_W-1:0] load_addr = '0;
  logic signed [WORD_W-1:0] load_word = '0;
  logic signed [WORD_W-1:0] read_value = '0;
  logic busy;
  logic done;
  logic [2:0] status;
  logic write_valid;
  logic signed [WORD_W-1:0] write_value;
  logic read_taken;
  logic [PC_W-1:0] next_pc;
  logic signed [WORD_W-1:0] acc_value;
  logic halted;

  // Our own image of the machine, advanced as each word is taken.
  logic signed [WORD_W-1:0] store_img [NWORDS];
  logic signed [WORD_W-1:0] acc_img = '0;
  logic [PC_W-1:0] pc_img = '0;
  logic stopped_img = 1'b0;

  outcome_t outcomes_due [$];

  int fail_count = 0;
  int cycle_count = 0;
  int burst_left = 4;
  int execs_sent = 0;
  int writes_sent = 0;
  int results_checked = 0;
  int outputs_seen = 0;
  int reads_seen = 0;
  int status_tally [8];
  string stop_kind = "none";

  decimal_accumulator_machine_top dut (
    .clk, .rst, .start, .busy, .func, .load_addr, .load_word, .read_value,
    .done, .status, .write_valid, .write_value, .read_taken, .next_pc,
    .acc_value, .halted
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles with %0d results outstanding",
             cycle_count, outcomes_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Words are clamped to the decimal range before they are stored.
  function automatic logic signed [WORD_W-1:0] clamp_word(input logic signed [WORD_W-1:0] v);
    if (v > WORD_LIMIT) return WORD_MAX;
    if (v < -WORD_LIMIT) return -WORD_MAX;
    return v;
  endfunction

  function automatic logic signed [WORD_W-1:0] instr(input logic [OP_W-1:0] opc, input int a);
    return WORD_W'(int'(opc) * 100 + a);
  endfunction

  function automatic bit known_op(input logic [OP_W-1:0] opc);
    case (opc)
      OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_DIV, OP_MUL,
      OP_BRANCH, OP_BRNEG, OP_BRZERO, OP_HALT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // True when the word at address at keeps the machine running: a known opcode
  // other than halt, and at the last address only an unconditional branch, so
  // that the program counter never falls off the end of the store.
  function automatic bit runs_on(input logic signed [WORD_W-1:0] w, input logic [PC_W-1:0] at);
    int v;
    logic [OP_W-1:0] opc;
    v = int'(w);
    if (v < 0) return 1'b0;
    opc = OP_W'(v / 100);
    if (at == NWORDS - 1) return opc == OP_BRANCH;
    return known_op(opc) && opc != OP_HALT;
  endfunction

  // Works out the machine's response to one word and moves the image on.
  function automatic outcome_t advance_machine(input logic fn, input logic [PC_W-1:0] addr,
                                               input logic signed [WORD_W-1:0] wrd,
                                               input logic signed [WORD_W-1:0] rdv);
    outcome_t o;
    int w, m, a, r, nxt, opnd;
    logic [OP_W-1:0] opc;
    o.status = ST_OK;
    o.write_valid = 1'b0;
    o.write_value = '0;
    o.read_taken = 1'b0;
    if (!fn) begin
      if (addr < NWORDS) store_img[addr] = clamp_word(wrd);
    end else if (stopped_img) begin
      o.status = ST_STOPPED;
    end else if (pc_img >= NWORDS) begin
      o.status = ST_PC_RANGE;
      stopped_img = 1'b1;
    end else begin
      w = int'(store_img[pc_img]);
      a = int'(acc_img);
      nxt = int'(pc_img) + 1;
      if (w < 0) begin
        o.status = ST_BAD_OP;
        stopped_img = 1'b1;
        nxt = int'(pc_img);
      end else begin
        opc = OP_W'(w / 100);
        opnd = w % 100;
        m = (opnd < NWORDS) ? int'(store_img[opnd]) : 0;
        case (opc)
          OP_READ: begin
            if (opnd < NWORDS) store_img[opnd] = clamp_word(rdv);
            o.read_taken = 1'b1;
          end
          OP_WRITE: begin
            o.write_valid = 1'b1;
            o.write_value = WORD_W'(m);
          end
          OP_LOAD: acc_img = WORD_W'(m);
          OP_STORE: begin
            if (opnd < NWORDS) store_img[opnd] = acc_img;
          end
          OP_ADD, OP_SUB, OP_MUL: begin
            r = (opc == OP_ADD) ? a + m : (opc == OP_SUB) ? a - m : a * m;
            if (r >= -WORD_LIMIT && r <= WORD_LIMIT) acc_img = WORD_W'(r);
            else o.status = ST_OVERFLOW;
          end
          // Integer division in SystemVerilog already truncates towards zero.
          OP_DIV: begin
            if (m == 0) o.status = ST_DIV_ZERO;
            else acc_img = WORD_W'(a / m);
          end
          OP_BRANCH: nxt = opnd;
          OP_BRNEG: begin
            if (a < 0) nxt = opnd;
          end
          OP_BRZERO: begin
            if (a == 0) nxt = opnd;
          end
          OP_HALT: begin
            o.status = ST_HALT;
            stopped_img = 1'b1;
            nxt = int'(pc_img);
          end
          default: begin
            o.status = ST_BAD_OP;
            stopped_img = 1'b1;
            nxt = int'(pc_img);
          end
        endcase
      end
      pc_img = PC_W'(nxt);
    end
    o.next_pc = pc_img;
    o.acc_value = acc_img;
    o.halted = stopped_img;
    return o;
  endfunction

  // Data values lean towards zero, small numbers and the range limits, with
  // some raw 15-bit patterns that lie outside the decimal range.
  function automatic logic signed [WORD_W-1:0] pick_value();
    logic signed [WORD_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1, 2, 3: v = WORD_W'(int'($urandom_range(0, 40)) - 20);
      4: v = $urandom_range(0, 1) ? WORD_W'(int'(WORD_MAX) - int'($urandom_range(0, 1)))
                                  : WORD_W'(-int'(WORD_MAX) + int'($urandom_range(0, 1)));
      5, 6, 7: v = WORD_W'(int'($urandom_range(0, 2 * WORD_LIMIT)) - WORD_LIMIT);
      default: v = WORD_W'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [PC_W-1:0] pick_addr();
    if ($urandom_range(0, 7) == 0) return PC_W'($urandom_range(NWORDS, 127));
    return PC_W'($urandom_range(0, NWORDS - 1));
  endfunction

  function automatic logic signed [WORD_W-1:0] random_instruction();
    logic [OP_W-1:0] opc;
    case ($urandom_range(0, 10))
      0: opc = OP_READ;
      1: opc = OP_WRITE;
      2: opc = OP_LOAD;
      3: opc = OP_STORE;
      4: opc = OP_ADD;
      5: opc = OP_SUB;
      6: opc = OP_DIV;
      7: opc = OP_MUL;
      8: opc = OP_BRANCH;
      9: opc = OP_BRNEG;
      default: opc = OP_BRZERO;
    endcase
    return instr(opc, int'($urandom_range(0, NWORDS - 1)));
  endfunction

  // Either a negative word or a positive one whose opcode is not in the set.
  function automatic logic signed [WORD_W-1:0] bad_word();
    int v;
    if ($urandom_range(0, 1) == 1) begin
      v = $urandom_range(16384, 32767);
      return WORD_W'(v);
    end
    do v = $urandom_range(0, 9999); while (known_op(OP_W'(v / 100)));
    return WORD_W'(v);
  endfunction

  // Lowers start for a while; the other inputs carry junk during the gap.
  task automatic take_break(input int cycles);
    start <= 1'b0;
    func <= 1'($urandom_range(0, 1));
    load_addr <= PC_W'($urandom());
    load_word <= WORD_W'($urandom());
    read_value <= WORD_W'($urandom());
    repeat (cycles) @(posedge clk);
  endtask

  // Presents one word and holds it until the machine takes it. The expected
  // response is worked out at the edge that takes the word. The sender runs
  // in bursts: mostly short ones, now and then a long stretch with no gaps.
  task automatic send_word(input logic fn, input logic [PC_W-1:0] addr,
                           input logic signed [WORD_W-1:0] wrd,
                           input logic signed [WORD_W-1:0] rdv);
    outcome_t o;
    start <= 1'b1;
    func <= fn;
    load_addr <= addr;
    load_word <= wrd;
    read_value <= rdv;
    @(posedge clk);
    while (busy) @(posedge clk);
    o = advance_machine(fn, addr, wrd, rdv);
    outcomes_due.push_back(o);
    status_tally[o.status]++;
    if (o.write_valid) outputs_seen++;
    if (o.read_taken) reads_seen++;
    if (fn) execs_sent++;
    else writes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      take_break($urandom_range(1, 20));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  // An execute word: the address and data fields are ignored but still random.
  task automatic run_instruction(input logic signed [WORD_W-1:0] rdv);
    send_word(1'b1, PC_W'($urandom_range(0, 127)), pick_value(), rdv);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Every strobed result is matched against the oldest response still due.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (outcomes_due.size() == 0) begin
        $error("result strobe with no word outstanding");
        fail_count++;
      end else begin
        want = outcomes_due.pop_front();
        results_checked++;
        check_field("status", 32'(want.status), 32'(status));
        check_field("write_valid", 32'(want.write_valid), 32'(write_valid));
        check_field("write_value", 32'(want.write_value), 32'(write_value));
        check_field("read_taken", 32'(want.read_taken), 32'(read_taken));
        check_field("next_pc", 32'(want.next_pc), 32'(next_pc));
        check_field("acc_value", 32'(want.acc_value), 32'(acc_value));
        check_field("halted", 32'(want.halted), 32'(halted));
      end
    end
  end

  // Memory writes at the limits: saturation from below with only the sign bit
  // of the word set, and an address past the store that must be ignored.
  task automatic test_word_writes();
    send_word(1'b0, 50, -15'sd16384, pick_value());
    send_word(1'b0, 127, -15'sd1, pick_value());
  endtask

  // A short program that runs every operation but halt and then loops back:
  // a read that saturates from above, a taken branch-if-negative, a subtract
  // and a multiply that overflow, a taken branch-if-zero, a divide by a word
  // that was never written (zero), an output, a divide that gives minus one,
  // a store and an unconditional branch.
  task automatic test_every_operation();
    send_word(1'b0, 0, instr(OP_READ, 51), pick_value());
    send_word(1'b0, 1, instr(OP_LOAD, 50), pick_value());
    send_word(1'b0, 2, instr(OP_BRNEG, 4), pick_value());
    send_word(1'b0, 4, instr(OP_SUB, 51), pick_value());
    send_word(1'b0, 5, instr(OP_ADD, 51), pick_value());
    send_word(1'b0, 6, instr(OP_BRZERO, 8), pick_value());
    send_word(1'b0, 8, instr(OP_DIV, 52), pick_value());
    send_word(1'b0, 9, instr(OP_WRITE, 51), pick_value());
    send_word(1'b0, 10, instr(OP_LOAD, 51), pick_value());
    send_word(1'b0, 11, instr(OP_MUL, 50), pick_value());
    send_word(1'b0, 12, instr(OP_DIV, 50), pick_value());
    send_word(1'b0, 13, instr(OP_STORE, 53), pick_value());
    send_word(1'b0, 14, instr(OP_BRANCH, 1), pick_value());
    run_instruction(15'sd16383);
    repeat (12) run_instruction(pick_value());
  endtask

  // Random programs that keep the machine running. Before each execute the
  // word at the program counter is replaced when it would stop the machine,
  // and now and then anyway so that tight loops do not settle in. Data writes
  // and planted instructions land all over the store in between.
  task automatic test_random_programs();
    int k;
    for (k = 0; k < RANDOM_PASSES; k++) begin
      case ($urandom_range(0, 9))
        0, 1: send_word(1'b0, pick_addr(), pick_value(), pick_value());
        2: send_word(1'b0, PC_W'($urandom_range(0, NWORDS - 2)), random_instruction(),
                     pick_value());
        default: begin
          if (!runs_on(store_img[pc_img], pc_img) || $urandom_range(0, 3) == 0) begin
            send_word(1'b0, pc_img,
                      (pc_img == NWORDS - 1)
                        ? instr(OP_BRANCH, int'($urandom_range(0, NWORDS - 1)))
                        : random_instruction(),
                      pick_value());
          end
          run_instruction(pick_value());
        end
      endcase
    end
  endtask

  // The machine can stop only once per run, so one cause is picked at random:
  // a halt, an unknown or negative word, or the program counter running past
  // the last word. After that, executes report the stopped state and memory
  // writes are still taken.
  task automatic test_stop_conditions();
    case ($urandom_range(0, 2))
      0: begin
        stop_kind = "halt";
        send_word(1'b0, pc_img, instr(OP_HALT, int'($urandom_range(0, NWORDS - 1))),
                  pick_value());
      end
      1: begin
        stop_kind = "bad opcode";
        send_word(1'b0, pc_img, bad_word(), pick_value());
      end
      default: begin
        stop_kind = "program counter overrun";
        send_word(1'b0, pc_img, instr(OP_BRANCH, NWORDS - 1), pick_value());
        send_word(1'b0, PC_W'(NWORDS - 1),
                  instr(OP_LOAD, int'($urandom_range(0, NWORDS - 1))), pick_value());
      end
    endcase
    while (!stopped_img) run_instruction(pick_value());
    repeat (3) run_instruction(pick_value());
    send_word(1'b0, pick_addr(), pick_value(), pick_value());
    run_instruction(pick_value());
  endtask

  initial begin
    for (int i = 0; i < NWORDS; i++) store_img[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_word_writes();
    test_every_operation();
    test_random_programs();
    test_stop_conditions();

    // Drain: wait for the last result, then allow a little more than the
    // divide latency in case a stray strobe follows.
    start <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);

    $display("Sent %0d words (%0d executes, %0d memory writes); %0d results compared.",
             execs_sent + writes_sent, execs_sent, writes_sent, results_checked);
    $display("Seen %0d overflows, %0d divides by zero, %0d outputs, %0d reads; stopped by %s.",
             status_tally[ST_OVERFLOW], status_tally[ST_DIV_ZERO], outputs_seen, reads_seen,
             stop_kind);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
